@@ rtl/cdpc_pkg.sv @@
package cdpc_pkg;

   localparam int PALETTE_DEPTH = 256;
   localparam int PAL_AW        = (PALETTE_DEPTH > 1) ? $clog2(PALETTE_DEPTH) : 1;

   localparam int COLOR_W = 24;
   localparam int COUNT_W = 9;
   localparam int CSR_W   = 9;

   typedef logic [COLOR_W-1:0] color_type;

   typedef enum logic [2:0] {
      FMT_1BPP  = 3'd0,
      FMT_4BPP  = 3'd1,
      FMT_8BPP  = 3'd2,
      FMT_24BPP = 3'd3,
      FMT_32BPP = 3'd4
   } fmt_type;

   typedef enum logic [1:0] {
      CSR_PIXEL_FORMAT     = 2'd0,
      CSR_PALETTE_COUNT    = 2'd1,
      CSR_USE_SOURCE_ALPHA = 2'd2
   } csr_idx_type;

   localparam logic [7:0] ALPHA_OPAQUE = 8'd255;

   typedef struct packed {
      logic                 wr_en;
      logic [7:0]           wr_slot;
      color_type            wr_color;
      logic                 rd_en;
      logic [7:0]           rd_index;
   } pal_ctrl_type;

   typedef struct packed {
      logic [31:0] pixel_data;
      logic [7:0]  column;
      logic [7:0]  mask_byte;
      logic [7:0]  index;
   } pix_type;

   function automatic logic is_indexed(input logic [2:0] fmt);
      logic r;
      case (fmt)
         FMT_1BPP, FMT_4BPP, FMT_8BPP: r = 1'b1;
         default:                      r = 1'b0;
      endcase
      return r;
   endfunction

   // Pick the palette index out of the source byte by format and column.
   function automatic logic [7:0] pixel_index(input logic [2:0] fmt,
                                              input logic [7:0] src,
                                              input logic [7:0] col);
      logic [7:0] r;
      case (fmt)
         FMT_1BPP: r = {7'd0, src[3'd7 - col[2:0]]};
         FMT_4BPP: r = col[0] ? {4'd0, src[3:0]} : {4'd0, src[7:4]};
         default:  r = src;
      endcase
      return r;
   endfunction

endpackage

@@ rtl/cdpc_palette.sv @@
module cdpc_palette
   import cdpc_pkg::*;
(
   input  logic         clock,
   input  pal_ctrl_type ctrl,
   output color_type    rd_color
);

   color_type mem_ff [PALETTE_DEPTH];
   color_type rd_ff;

   localparam logic [8:0] DEPTH_LIM = 9'(PALETTE_DEPTH);

   // Drop writes to slots the table does not hold.
   always_ff @(posedge clock) begin
      if (ctrl.wr_en && ({1'b0, ctrl.wr_slot} < DEPTH_LIM)) begin
         mem_ff[ctrl.wr_slot[PAL_AW-1:0]] <= ctrl.wr_color;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.rd_en) begin
         rd_ff <= mem_ff[ctrl.rd_index[PAL_AW-1:0]];
      end
   end

   assign rd_color = rd_ff;

endmodule

@@ rtl/cursor_dib_pixel_converter_core.sv @@
// Cursor DIB pixel converter: takes one item per clock and turns 1, 4, 8, 24 or
// 32 bpp cursor pixels into RGBA with the AND mask applied. A palette write item
// (req_tuser 0) loads one color table entry and gives no result; a pixel item
// gives exactly one result by way of the palette read register and the output
// register. Back-to-back items are taken every cycle while the result side
// keeps up. Palette entries must be written before a pixel reads them. In
// indexed formats, indices at or above palette_count give index_error with
// all color and alpha bytes zero. Write the csr registers only while idle.
module cursor_dib_pixel_converter_core
   import cdpc_pkg::*;
(
   input  logic         clock,
   input  logic         reset,

   input  logic         req_tvalid,
   output logic         req_tready,
   // palette_slot, palette_color, pixel_data, column, mask_byte (from bit 0)
   input  logic [79:0]  req_tdata,
   // req_type
   input  logic [0:0]   req_tuser,

   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // red, green, blue, alpha (from bit 0)
   output logic [31:0]  rsp_tdata,
   // index_error
   output logic [0:0]   rsp_tuser,

   input  logic         csr_wr_en,
   input  logic [1:0]   csr_index,
   input  logic [CSR_W-1:0] csr_wdata
);

   logic [2:0]         fmt_ff;
   logic [COUNT_W-1:0] count_ff;
   logic               src_alpha_ff;

   logic               s1_valid_ff, s1_valid_in;
   pix_type            s1_ff;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [31:0]        rsp_data_ff, rsp_data_in;
   logic               rsp_err_ff, rsp_err_in;

   logic               req_acc, pix_acc, move1;
   pal_ctrl_type       pal_ctrl;
   color_type          pal_color;
   logic [7:0]         idx_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         fmt_ff       <= FMT_8BPP;
         count_ff     <= COUNT_W'(PALETTE_DEPTH);
         src_alpha_ff <= 1'b0;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_PIXEL_FORMAT:     fmt_ff       <= csr_wdata[2:0];
            CSR_PALETTE_COUNT:    count_ff     <= csr_wdata[COUNT_W-1:0];
            CSR_USE_SOURCE_ALPHA: src_alpha_ff <= csr_wdata[0];
            default:              ;
         endcase
      end
   end

   // Handshake: stage 1 moves on when the output register is free or drains.
   assign move1      = s1_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !s1_valid_ff || move1;
   assign req_acc    = req_tvalid && req_tready;
   assign pix_acc    = req_acc && req_tuser[0];

   assign idx_in = pixel_index(fmt_ff, req_tdata[39:32], req_tdata[71:64]);

   always_comb begin
      pal_ctrl.wr_en    = req_acc && !req_tuser[0];
      pal_ctrl.wr_slot  = req_tdata[7:0];
      pal_ctrl.wr_color = req_tdata[31:8];
      pal_ctrl.rd_en    = pix_acc;
      pal_ctrl.rd_index = idx_in;
   end

   cdpc_palette u_palette (
      .clock    (clock),
      .ctrl     (pal_ctrl),
      .rd_color (pal_color)
   );

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (move1) s1_valid_in = 1'b0;
      if (pix_acc) s1_valid_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pix_acc) begin
         s1_ff.pixel_data <= req_tdata[63:32];
         s1_ff.column     <= req_tdata[71:64];
         s1_ff.mask_byte  <= req_tdata[79:72];
         s1_ff.index      <= idx_in;
      end
   end

   // Result: palette or direct color, alpha, mask, index check.
   always_comb begin
      logic       masked;
      logic       bad;
      logic [7:0] a;
      masked = s1_ff.mask_byte[3'd7 - s1_ff.column[2:0]];
      bad    = ({1'b0, s1_ff.index} >= count_ff) ||
               ({1'b0, s1_ff.index} >= 9'(PALETTE_DEPTH));
      a      = ALPHA_OPAQUE;
      if ((fmt_ff == FMT_32BPP) && src_alpha_ff) a = s1_ff.pixel_data[31:24];
      if (masked) a = 8'd0;
      rsp_err_in = 1'b0;
      if (is_indexed(fmt_ff)) begin
         if (bad) begin
            rsp_err_in  = 1'b1;
            rsp_data_in = 32'd0;
         end else begin
            rsp_data_in = {a, pal_color[7:0], pal_color[15:8], pal_color[23:16]};
         end
      end else begin
         rsp_data_in = {a, s1_ff.pixel_data[7:0], s1_ff.pixel_data[15:8],
                        s1_ff.pixel_data[23:16]};
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_tready) rsp_valid_in = 1'b0;
      if (move1) rsp_valid_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (move1) begin
         rsp_data_ff <= rsp_data_in;
         rsp_err_ff  <= rsp_err_in;
      end
   end

   assign rsp_tvalid   = rsp_valid_ff;
   assign rsp_tdata    = rsp_data_ff;
   assign rsp_tuser[0] = rsp_err_ff;

   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser[0]) |-> (rsp_tdata == 32'd0))
      else $error("index error result carries nonzero data");

   a_write_no_result: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready && !req_tuser[0] && !s1_valid_ff) |=> !s1_valid_ff)
      else $error("palette write item entered the pixel pipeline");

   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> (s1_valid_ff && rsp_valid_ff && !rsp_tready))
      else $error("input stalled without a full pipeline");

   a_move_fills: assert property (@(posedge clock) disable iff (reset)
      move1 |=> rsp_valid_ff)
      else $error("item left stage 1 without reaching the output register");

endmodule
